@@ rtl/core/ddpi_pkg.sv @@
// Shared types, codes and constants of the differential-drive pose integrator.
// No dependencies.
package ddpi_pkg;

  localparam int DATA_W           = 32;
  localparam int WIDE_W           = 48;
  localparam int ACC_W            = 80;
  localparam int CORDIC_STEPS_DEF = 24;
  localparam int CORDIC_W         = 34;
  localparam int ADDR_W           = 4;

  localparam logic signed [WIDE_W-1:0]   WIDE_LIM   = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [WIDE_W-1:0]   WIDE_MIN   = 48'sh8000_0000_0000;
  localparam logic signed [WIDE_W-1:0]   DIST_LIM   = 48'sh0001_FFFF_FFFF;
  localparam logic signed [CORDIC_W-1:0] CORDIC_X0  = 34'sd652032874;
  localparam logic signed [CORDIC_W-1:0] Q30_ONE    = 34'sd1073741824;
  localparam logic [DATA_W-1:0]          RAD_TO_BAM = 32'd683565276;
  localparam logic [DATA_W-1:0]          QUARTER    = 32'h4000_0000;
  localparam logic [DATA_W-1:0]          HALF       = 32'h8000_0000;

  localparam logic [DATA_W-1:0] TIME_STEP_RST = 32'd655;
  localparam logic [DATA_W-1:0] RADIUS_RST    = 32'd65536;
  localparam logic [DATA_W-1:0] INV_AXLE_RST  = 32'd32768;

  localparam logic [1:0] REG_MODE     = 2'd0;
  localparam logic [1:0] REG_DT       = 2'd1;
  localparam logic [1:0] REG_RADIUS   = 2'd2;
  localparam logic [1:0] REG_INV_AXLE = 2'd3;

  localparam logic [3:0] A_SUM    = 4'd0;
  localparam logic [3:0] A_DIFF   = 4'd1;
  localparam logic [3:0] A_SUM_E  = 4'd2;
  localparam logic [3:0] A_T      = 4'd3;
  localparam logic [3:0] A_T_HALF = 4'd4;
  localparam logic [3:0] A_Q      = 4'd5;
  localparam logic [3:0] A_SPDA   = 4'd6;
  localparam logic [3:0] A_SPDB   = 4'd7;
  localparam logic [3:0] A_RAD    = 4'd8;
  localparam logic [3:0] A_DIST   = 4'd9;

  localparam logic [2:0] B_R   = 3'd0;
  localparam logic [2:0] B_K   = 3'd1;
  localparam logic [2:0] B_DT  = 3'd2;
  localparam logic [2:0] B_BAM = 3'd3;
  localparam logic [2:0] B_COS = 3'd4;
  localparam logic [2:0] B_SIN = 3'd5;

  localparam logic [3:0] D_T      = 4'd0;
  localparam logic [3:0] D_LIN    = 4'd1;
  localparam logic [3:0] D_Q      = 4'd2;
  localparam logic [3:0] D_DIST   = 4'd3;
  localparam logic [3:0] D_DIST_E = 4'd4;
  localparam logic [3:0] D_RAD    = 4'd5;
  localparam logic [3:0] D_HEAD   = 4'd6;
  localparam logic [3:0] D_X      = 4'd7;
  localparam logic [3:0] D_Y      = 4'd8;

  typedef struct packed {
    logic [3:0] asel;
    logic [2:0] bsel;
    logic [3:0] dst;
  } uop_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic mul_lo;
    logic mul_hi;
    logic wb;
    logic commit;
    uop_t uop;
  } cmd_t;

  typedef struct packed {
    logic cordic_done;
    logic out_hold;
  } sts_t;

  function automatic logic [DATA_W-1:0] atan_lut(input logic [4:0] i);
    logic [DATA_W-1:0] v;
    unique case (i)
      5'd0:  v = 32'h2000_0000;
      5'd1:  v = 32'h12E4_051E;
      5'd2:  v = 32'h09FB_385B;
      5'd3:  v = 32'h0511_11D4;
      5'd4:  v = 32'h028B_0D43;
      5'd5:  v = 32'h0145_D7E1;
      5'd6:  v = 32'h00A2_F61E;
      5'd7:  v = 32'h0051_7C55;
      5'd8:  v = 32'h0028_BE53;
      5'd9:  v = 32'h0014_5F2F;
      5'd10: v = 32'h000A_2F98;
      5'd11: v = 32'h0005_17CC;
      5'd12: v = 32'h0002_8BE6;
      5'd13: v = 32'h0001_45F3;
      5'd14: v = 32'h0000_A2FA;
      5'd15: v = 32'h0000_517D;
      5'd16: v = 32'h0000_28BE;
      5'd17: v = 32'h0000_145F;
      5'd18: v = 32'h0000_0A30;
      5'd19: v = 32'h0000_0518;
      5'd20: v = 32'h0000_028C;
      5'd21: v = 32'h0000_0146;
      5'd22: v = 32'h0000_00A3;
      5'd23: v = 32'h0000_0051;
      5'd24: v = 32'h0000_0029;
      5'd25: v = 32'h0000_0014;
      5'd26: v = 32'h0000_000A;
      5'd27: v = 32'h0000_0005;
      5'd28: v = 32'h0000_0003;
      5'd29: v = 32'h0000_0001;
      5'd30: v = 32'h0000_0001;
      5'd31: v = 32'h0000_0000;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/core/diff_drive_pose_integrator.sv @@
// Differential-drive pose integrator. One item at a time: the next input is taken only
// once the result is registered, and a result still waiting on out_ready holds the
// commit of the next one. Synchronous active-low reset clears pose to zero and
// loads register defaults (mode 0, dt 655, radius 65536, 1/(2l) 32768).
module diff_drive_pose_integrator #(
  parameter int CORDIC_STEPS = ddpi_pkg::CORDIC_STEPS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ddpi_pkg::ADDR_W-1:0]        paddr,
  input  logic [ddpi_pkg::DATA_W-1:0]        pwdata,
  output logic [ddpi_pkg::DATA_W-1:0]        prdata,
  output logic                               pready,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [ddpi_pkg::DATA_W-1:0] in_speed_a,
  input  logic signed [ddpi_pkg::DATA_W-1:0] in_speed_b,
  input  logic signed [ddpi_pkg::DATA_W-1:0] in_dist_noise,
  input  logic signed [ddpi_pkg::DATA_W-1:0] in_angle_noise,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [ddpi_pkg::DATA_W-1:0] out_pos_x,
  output logic signed [ddpi_pkg::DATA_W-1:0] out_pos_y,
  output logic [ddpi_pkg::DATA_W-1:0]        out_heading,
  output logic signed [ddpi_pkg::DATA_W-1:0] out_lin_vel,
  output logic signed [ddpi_pkg::DATA_W-1:0] out_ang_vel
);
  import ddpi_pkg::*;

  logic              mode_r;
  logic [DATA_W-1:0] dt_r, radius_r, inv_axle_r;
  logic [1:0]        reg_idx;
  logic              wr_en;
  cmd_t              cmd;
  sts_t              sts;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= 1'b0;
      dt_r       <= TIME_STEP_RST;
      radius_r   <= RADIUS_RST;
      inv_axle_r <= INV_AXLE_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MODE:     mode_r     <= pwdata[0];
        REG_DT:       dt_r       <= pwdata;
        REG_RADIUS:   radius_r   <= pwdata;
        REG_INV_AXLE: inv_axle_r <= pwdata;
        default:      mode_r     <= mode_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MODE:     prdata = {{(DATA_W-1){1'b0}}, mode_r};
      REG_DT:       prdata = dt_r;
      REG_RADIUS:   prdata = radius_r;
      REG_INV_AXLE: prdata = inv_axle_r;
      default:      prdata = '0;
    endcase
  end

  ddpi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .mode     (mode_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ddpi_dp #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .time_step      (dt_r),
    .wheel_radius   (radius_r),
    .inv_twice_axle (inv_axle_r),
    .in_speed_a     (in_speed_a),
    .in_speed_b     (in_speed_b),
    .in_dist_noise  (in_dist_noise),
    .in_angle_noise (in_angle_noise),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pos_x      (out_pos_x),
    .out_pos_y      (out_pos_y),
    .out_heading    (out_heading),
    .out_lin_vel    (out_lin_vel),
    .out_ang_vel    (out_ang_vel)
  );

endmodule

@@ rtl/core/ddpi_cordic.sv @@
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, gives cos and sin.
// Depends on ddpi_pkg.
module ddpi_cordic #(
  parameter int CORDIC_STEPS = ddpi_pkg::CORDIC_STEPS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [ddpi_pkg::DATA_W-1:0]        angle,
  output logic                               done,
  output logic signed [ddpi_pkg::DATA_W-1:0] cos_o,
  output logic signed [ddpi_pkg::DATA_W-1:0] sin_o
);
  import ddpi_pkg::*;

  localparam int CW = $clog2(CORDIC_STEPS + 1);

  logic signed [CORDIC_W-1:0] x_r, y_r, z_r, x_nxt, y_nxt, z_nxt;
  logic signed [CORDIC_W-1:0] xc, yc, atan_v;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic                       flip_r, flip_nxt;
  logic [DATA_W-1:0]          fold;
  logic [4:0]                 idx;

  assign done   = (cnt_r == CW'(CORDIC_STEPS));
  assign idx    = 5'(cnt_r);
  assign atan_v = CORDIC_W'(atan_lut(idx));

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    cnt_nxt  = cnt_r;
    flip_nxt = flip_r;
    fold     = angle + QUARTER;
    if (start) begin
      flip_nxt = fold[DATA_W-1];
      x_nxt    = CORDIC_X0;
      y_nxt    = '0;
      z_nxt    = CORDIC_W'($signed(fold[DATA_W-1] ? (angle ^ HALF) : angle));
      cnt_nxt  = '0;
    end else if (!done) begin
      if (!z_r[CORDIC_W-1]) begin
        x_nxt = x_r - (y_r >>> idx);
        y_nxt = y_r + (x_r >>> idx);
        z_nxt = z_r - atan_v;
      end else begin
        x_nxt = x_r + (y_r >>> idx);
        y_nxt = y_r - (x_r >>> idx);
        z_nxt = z_r + atan_v;
      end
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= CW'(CORDIC_STEPS);
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    flip_r <= flip_nxt;
  end

  always_comb begin
    xc = (x_r > Q30_ONE) ? Q30_ONE : ((x_r < -Q30_ONE) ? -Q30_ONE : x_r);
    yc = (y_r > Q30_ONE) ? Q30_ONE : ((y_r < -Q30_ONE) ? -Q30_ONE : y_r);
    cos_o = DATA_W'(flip_r ? -xc : xc);
    sin_o = DATA_W'(flip_r ? -yc : yc);
  end

endmodule

@@ rtl/core/ddpi_mul.sv @@
// Two-pass 48 x 32 multiplier: low and high 16-bit halves of B into an 80-bit sum.
// Depends on ddpi_pkg.
module ddpi_mul (
  input  logic                              clk,
  input  logic                              mul_lo,
  input  logic                              mul_hi,
  input  logic signed [ddpi_pkg::WIDE_W-1:0] opa,
  input  logic [ddpi_pkg::DATA_W-1:0]       opb,
  input  logic                              b_signed,
  output logic signed [ddpi_pkg::ACC_W-1:0] acc
);
  import ddpi_pkg::*;

  logic signed [16:0]          bpart;
  logic signed [WIDE_W+16:0]   prod;
  logic signed [ACC_W-1:0]     acc_r, acc_nxt;

  assign bpart = mul_hi ? {b_signed & opb[DATA_W-1], opb[31:16]} : {1'b0, opb[15:0]};
  assign prod  = opa * bpart;
  assign acc   = acc_r;

  always_comb begin
    acc_nxt = acc_r;
    if (mul_lo) begin
      acc_nxt = {{(ACC_W-WIDE_W-17){prod[WIDE_W+16]}}, prod};
    end else if (mul_hi) begin
      acc_nxt = acc_r + {prod[63:0], 16'b0};
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

endmodule

@@ rtl/core/ddpi_dp.sv @@
// Datapath: operand select, shared multiplier, CORDIC, pose state and result beat.
// Depends on ddpi_pkg, ddpi_mul and ddpi_cordic.
module ddpi_dp #(
  parameter int CORDIC_STEPS = ddpi_pkg::CORDIC_STEPS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ddpi_pkg::cmd_t                     cmd,
  output ddpi_pkg::sts_t                     sts,
  input  logic [ddpi_pkg::DATA_W-1:0]        time_step,
  input  logic [ddpi_pkg::DATA_W-1:0]        wheel_radius,
  input  logic [ddpi_pkg::DATA_W-1:0]        inv_twice_axle,
  input  logic signed [ddpi_pkg::DATA_W-1:0] in_speed_a,
  input  logic signed [ddpi_pkg::DATA_W-1:0] in_speed_b,
  input  logic signed [ddpi_pkg::DATA_W-1:0] in_dist_noise,
  input  logic signed [ddpi_pkg::DATA_W-1:0] in_angle_noise,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [ddpi_pkg::DATA_W-1:0] out_pos_x,
  output logic signed [ddpi_pkg::DATA_W-1:0] out_pos_y,
  output logic [ddpi_pkg::DATA_W-1:0]        out_heading,
  output logic signed [ddpi_pkg::DATA_W-1:0] out_lin_vel,
  output logic signed [ddpi_pkg::DATA_W-1:0] out_ang_vel
);
  import ddpi_pkg::*;

  function automatic logic signed [DATA_W-1:0] sat_w(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi, lo;
    hi = WIDE_W'(32'sh7FFF_FFFF);
    lo = WIDE_W'(32'sh8000_0000);
    return (v > hi) ? DATA_W'(hi) : ((v < lo) ? DATA_W'(lo) : DATA_W'(v));
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_p(input logic signed [50:0] v);
    logic signed [50:0] hi, lo;
    hi = 51'(32'sh7FFF_FFFF);
    lo = 51'(32'sh8000_0000);
    return (v > hi) ? DATA_W'(hi) : ((v < lo) ? DATA_W'(lo) : DATA_W'(v));
  endfunction

  function automatic logic signed [WIDE_W-1:0] clamp_d(input logic signed [WIDE_W:0] v);
    logic signed [WIDE_W:0] lim;
    lim = (WIDE_W+1)'(DIST_LIM);
    return (v > lim) ? DIST_LIM : ((v < -lim) ? -DIST_LIM : WIDE_W'(v));
  endfunction

  logic signed [DATA_W-1:0] a_r, b_r, e0_r, lin_r, angv_r, xn_r, yn_r;
  logic signed [DATA_W-1:0] x_acc_r, y_acc_r, out_lin_r, out_angv_r;
  logic [DATA_W-1:0]        theta_r, hinc_r, opb_r, bmux;
  logic signed [WIDE_W-1:0] t_r, q_r, dist_r, rad_r, opa_r, amux, amux_c, rw;
  logic signed [WIDE_W-1:0] a_ext, b_ext, e_ext;
  logic signed [63:0]       res16;
  logic signed [49:0]       inc;
  logic [3:0]               dst_r;
  logic                     bsgn_r, bsgn;
  logic                     out_valid_r;
  logic signed [ACC_W-1:0]  acc;
  logic signed [DATA_W-1:0] cos_v, sin_v;
  logic                     cdone;

  ddpi_mul u_mul (
    .clk      (clk),
    .mul_lo   (cmd.mul_lo),
    .mul_hi   (cmd.mul_hi),
    .opa      (opa_r),
    .opb      (opb_r),
    .b_signed (bsgn_r),
    .acc      (acc)
  );

  ddpi_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.load),
    .angle (theta_r + in_angle_noise),
    .done  (cdone),
    .cos_o (cos_v),
    .sin_o (sin_v)
  );

  assign a_ext = WIDE_W'(a_r);
  assign b_ext = WIDE_W'(b_r);
  assign e_ext = WIDE_W'(e0_r);

  always_comb begin
    unique case (cmd.uop.asel)
      A_SUM:    amux = a_ext + b_ext;
      A_DIFF:   amux = a_ext - b_ext;
      A_SUM_E:  amux = a_ext + b_ext + e_ext;
      A_T:      amux = t_r;
      A_T_HALF: amux = t_r >>> 1;
      A_Q:      amux = q_r;
      A_SPDA:   amux = a_ext;
      A_SPDB:   amux = b_ext;
      A_RAD:    amux = rad_r;
      A_DIST:   amux = dist_r;
      default:  amux = '0;
    endcase
    amux_c = (amux == WIDE_MIN) ? -WIDE_LIM : amux;
    unique case (cmd.uop.bsel)
      B_R:     bmux = wheel_radius;
      B_K:     bmux = inv_twice_axle;
      B_DT:    bmux = time_step;
      B_BAM:   bmux = RAD_TO_BAM;
      B_COS:   bmux = cos_v;
      B_SIN:   bmux = sin_v;
      default: bmux = '0;
    endcase
    bsgn = (cmd.uop.bsel == B_COS) || (cmd.uop.bsel == B_SIN);
  end

  always_comb begin
    res16 = acc[ACC_W-1:16];
    if (res16 > 64'(WIDE_LIM)) begin
      rw = WIDE_LIM;
    end else if (res16 < -64'(WIDE_LIM)) begin
      rw = -WIDE_LIM;
    end else begin
      rw = WIDE_W'(res16);
    end
    inc = acc[ACC_W-1:30];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r    <= in_speed_a;
      b_r    <= in_speed_b;
      e0_r   <= in_dist_noise;
      lin_r  <= in_speed_a;
      angv_r <= in_speed_b;
    end
    if (cmd.issue) begin
      opa_r  <= amux_c;
      opb_r  <= bmux;
      bsgn_r <= bsgn;
      dst_r  <= cmd.uop.dst;
    end
    if (cmd.wb) begin
      unique case (dst_r)
        D_T:      t_r <= rw;
        D_LIN: begin
          t_r   <= rw;
          lin_r <= sat_w(rw >>> 1);
        end
        D_Q: begin
          q_r    <= rw;
          angv_r <= sat_w(rw);
        end
        D_DIST:   dist_r <= clamp_d((WIDE_W+1)'(rw));
        D_DIST_E: dist_r <= clamp_d((WIDE_W+1)'(rw) + (WIDE_W+1)'(e0_r));
        D_RAD:    rad_r  <= rw;
        D_HEAD:   hinc_r <= acc[47:16];
        D_X:      xn_r   <= sat_p(51'(x_acc_r) + 51'(inc));
        D_Y:      yn_r   <= sat_p(51'(y_acc_r) + 51'(inc));
        default:  t_r    <= t_r;
      endcase
    end
    if (cmd.commit) begin
      out_lin_r  <= lin_r;
      out_angv_r <= angv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_acc_r     <= '0;
      y_acc_r     <= '0;
      theta_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        x_acc_r     <= xn_r;
        y_acc_r     <= yn_r;
        theta_r     <= theta_r + hinc_r;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.cordic_done = cdone;
  assign sts.out_hold    = out_valid_r && !out_ready;

  assign out_valid   = out_valid_r;
  assign out_pos_x   = x_acc_r;
  assign out_pos_y   = y_acc_r;
  assign out_heading = theta_r;
  assign out_lin_vel = out_lin_r;
  assign out_ang_vel = out_angv_r;

endmodule

@@ rtl/core/ddpi_ctrl.sv @@
// Controller: sequences the multiply program, waits on the CORDIC, commits the pose.
// Depends on ddpi_pkg.
module ddpi_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           mode,
  input  logic           in_valid,
  output logic           in_ready,
  input  ddpi_pkg::sts_t sts,
  output ddpi_pkg::cmd_t cmd
);
  import ddpi_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ISSUE = 3'd1;
  localparam logic [2:0] S_LO    = 3'd2;
  localparam logic [2:0] S_HI    = 3'd3;
  localparam logic [2:0] S_WB    = 3'd4;
  localparam logic [2:0] S_WAITC = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  localparam logic [3:0] STEP_M1_FIRST = 4'd0;
  localparam logic [3:0] STEP_M0_FIRST = 4'd4;
  localparam logic [3:0] STEP_PRE_TRIG = 4'd5;
  localparam logic [3:0] STEP_LAST     = 4'd8;

  function automatic uop_t prog(input logic m, input logic [3:0] s);
    uop_t u;
    u = '{asel: A_DIST, bsel: B_SIN, dst: D_Y};
    unique case (s)
      4'd0: u = '{asel: A_SUM,    bsel: B_R,   dst: D_LIN};
      4'd1: u = '{asel: A_DIFF,   bsel: B_R,   dst: D_T};
      4'd2: u = '{asel: A_T,      bsel: B_K,   dst: D_Q};
      4'd3: u = '{asel: A_SUM_E,  bsel: B_R,   dst: D_T};
      4'd4: u = m ? uop_t'{asel: A_T_HALF, bsel: B_DT, dst: D_DIST}
                  : uop_t'{asel: A_SPDA,   bsel: B_DT, dst: D_DIST_E};
      4'd5: u = m ? uop_t'{asel: A_Q,    bsel: B_DT, dst: D_RAD}
                  : uop_t'{asel: A_SPDB, bsel: B_DT, dst: D_RAD};
      4'd6: u = '{asel: A_RAD,    bsel: B_BAM, dst: D_HEAD};
      4'd7: u = '{asel: A_DIST,   bsel: B_COS, dst: D_X};
      default: u = '{asel: A_DIST, bsel: B_SIN, dst: D_Y};
    endcase
    return u;
  endfunction

  logic [2:0] state_r, state_nxt;
  logic [3:0] step_r, step_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    cmd        = '0;
    cmd.uop    = prog(mode, step_r);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          step_nxt  = mode ? STEP_M1_FIRST : STEP_M0_FIRST;
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd.issue = 1'b1;
        state_nxt = S_LO;
      end
      S_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_HI;
      end
      S_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_WB;
      end
      S_WB: begin
        cmd.wb = 1'b1;
        if (step_r == STEP_LAST) begin
          state_nxt = S_FIN;
        end else begin
          step_nxt  = step_r + 1'b1;
          state_nxt = (step_r == STEP_PRE_TRIG) ? S_WAITC : S_ISSUE;
        end
      end
      S_WAITC: begin
        if (sts.cordic_done) begin
          state_nxt = S_ISSUE;
        end
      end
      S_FIN: begin
        if (!sts.out_hold) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= STEP_M1_FIRST;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule
